@@ rtl/brd_pkg.sv @@
// Shared constants, types and arithmetic helpers of the RGGB Bayer demosaic.
`timescale 1ns / 1ps

package brd_pkg;

  // Field and register widths.
  localparam int unsigned PIX_W  = 8;
  localparam int unsigned RAW_W  = 16;
  localparam int unsigned SIZE_W = 13;
  localparam int unsigned CFG_AW = 1;

  // Default line and frame limits.
  localparam int unsigned DEF_MAX_WIDTH  = 4096;
  localparam int unsigned DEF_MAX_HEIGHT = 4096;
  localparam int unsigned MIN_SIZE       = 4;

  // Size registers after reset.
  localparam logic [SIZE_W-1:0] RESET_WIDTH  = 13'd640;
  localparam logic [SIZE_W-1:0] RESET_HEIGHT = 13'd480;

  // Output lags the input by this many rows and columns.
  localparam int unsigned LAG = 3;

  // Window geometry: rows r-2 .. r+3, columns c-3 .. c+3.
  localparam int unsigned WIN_ROWS  = 6;
  localparam int unsigned WIN_COLS  = 7;
  localparam int unsigned ROW_TOP   = 2;
  localparam int unsigned LINE_BUFS = WIN_ROWS - 1;

  // Register indexes of the configuration port.
  localparam logic [CFG_AW-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_AW-1:0] REG_FRAME_HEIGHT = 1'b1;

  // Input beat kinds.
  localparam logic KIND_FLUSH = 1'b1;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic signed [9:0] lap_t;

  typedef struct packed {
    logic last;
    pix_t blue;
    pix_t green;
    pix_t red;
  } pixel_t;

  // Magnitude of a 9-bit signed difference.
  function automatic logic [8:0] mag9(input logic signed [8:0] v);
    logic [8:0] r;
    r = (v < 0) ? 9'(-v) : 9'(v);
    return r;
  endfunction

  // Magnitude of a Laplacian term.
  function automatic logic [9:0] mag10(input lap_t v);
    logic [9:0] r;
    r = (v < 0) ? 10'(-v) : 10'(v);
    return r;
  endfunction

  // Second difference 2c - p - q.
  function automatic lap_t lap(input pix_t c, input pix_t p, input pix_t q);
    lap_t r;
    r = $signed({1'b0, c, 1'b0}) - $signed({2'b00, p}) - $signed({2'b00, q});
    return r;
  endfunction

  // Truncated mean of two samples.
  function automatic pix_t half_sum(input pix_t a, input pix_t b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[8:1];
  endfunction

  // Directional interpolation: pick the direction with the smaller gradient,
  // add a quarter of its Laplacian, or blend both on a tie. Divisions
  // truncate toward zero and the result clamps to 0..255.
  function automatic pix_t dir_pick(input pix_t a, input pix_t b, input lap_t x2,
                                    input pix_t c, input pix_t d, input lap_t y2);
    logic signed [8:0]  dab;
    logic signed [8:0]  dcd;
    logic [9:0]         ga;
    logic [9:0]         gb;
    lap_t               qx;
    lap_t               qy;
    logic [9:0]         s4;
    logic signed [10:0] sxy;
    logic signed [10:0] qs;
    logic signed [11:0] v;
    pix_t               res;
    dab = $signed({1'b0, a}) - $signed({1'b0, b});
    dcd = $signed({1'b0, c}) - $signed({1'b0, d});
    ga  = {1'b0, mag9(dab)} + mag10(x2);
    gb  = {1'b0, mag9(dcd)} + mag10(y2);
    qx  = (x2 >>> 2) + ((x2 < 0 && x2[1:0] != 2'b00) ? 10'sd1 : 10'sd0);
    qy  = (y2 >>> 2) + ((y2 < 0 && y2[1:0] != 2'b00) ? 10'sd1 : 10'sd0);
    s4  = 10'(a) + 10'(b) + 10'(c) + 10'(d);
    sxy = 11'(x2) + 11'(y2);
    qs  = (sxy >>> 3) + ((sxy < 0 && sxy[2:0] != 3'b000) ? 11'sd1 : 11'sd0);
    if (ga < gb) begin
      v = $signed({4'b0000, half_sum(a, b)}) + 12'(qx);
    end else if (ga > gb) begin
      v = $signed({4'b0000, half_sum(c, d)}) + 12'(qy);
    end else begin
      v = $signed({4'b0000, s4[9:2]}) + 12'(qs);
    end
    if (v < 0) begin
      res = '0;
    end else if (v > 12'sd255) begin
      res = '1;
    end else begin
      res = v[7:0];
    end
    return res;
  endfunction

  // Green at a red or blue site from its cross of neighbors.
  function automatic pix_t green_at(input pix_t c, input pix_t l1, input pix_t r1,
                                    input pix_t t1, input pix_t b1, input pix_t l2,
                                    input pix_t r2, input pix_t t2, input pix_t b2);
    return dir_pick(l1, r1, lap(c, l2, r2), t1, b1, lap(c, t2, b2));
  endfunction

endpackage

@@ rtl/bayer_rggb_demosaic.sv @@
// Streaming RGGB Bayer demosaic with gradient-directed green and diagonal fill.
//
// Usage: raw samples enter on the s_axis channel in raster order, one per beat;
// tuser marks a flush beat. Only bits 15..8 of each sample are used. The
// m_axis channel returns one RGB pixel per beat, tlast on the last pixel of a
// frame. Pixel q of a frame completes on the input beat that carries sample
// q + 3*W + 3; after the last sample, 3*W + 3 flush beats drain the tail, one
// pixel each. Flush beats before that point are taken and dropped.
// A completed result passes through stage 1, stage 2, stage 3 and the output
// register. Throughput: one beat per cycle while the skid register is empty,
// set by the single read and write port of each line memory, visited once per column.
// Frame size comes from the configuration port; write it only between frames.
// Reset loads a 640 x 480 frame and clears all positions and valid flags; the
// line memories are not cleared, since entries outside the frame are masked.
// When the receiver stalls, a result register and one skid register hold
// finished pixels; s_axis_tready falls only while the skid register is full.
`timescale 1ns / 1ps

module bayer_rggb_demosaic #(
  parameter int unsigned MAX_WIDTH  = brd_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = brd_pkg::DEF_MAX_HEIGHT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Configuration write port.
  input  logic                        cfg_we_i,
  input  logic [brd_pkg::CFG_AW-1:0]  cfg_addr_i,
  input  logic [brd_pkg::SIZE_W-1:0]  cfg_wdata_i,
  // Input stream.
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [brd_pkg::RAW_W-1:0]   s_axis_tdata_i,   // [15:0] raw_sample
  input  logic                        s_axis_tuser_i,   // [0] kind
  // Output stream.
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [3*brd_pkg::PIX_W-1:0] m_axis_tdata_o,   // [7:0] red, [15:8] green,
                                                        // [23:16] blue
  output logic                        m_axis_tlast_o    // frame_end
);
  import brd_pkg::*;

  localparam int unsigned XW  = $clog2(MAX_WIDTH);
  localparam int unsigned WCW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HCW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned RW  = $clog2(MAX_HEIGHT);
  localparam int unsigned NYW = $clog2(MAX_HEIGHT + LAG + 1);
  localparam int unsigned EWW = (WCW > SIZE_W) ? WCW : SIZE_W;
  localparam int unsigned EHW = (HCW > SIZE_W) ? HCW : SIZE_W;

  // Configuration registers.
  logic [SIZE_W-1:0] cfg_w_q, cfg_h_q;
  logic [WCW-1:0]    effw;
  logic [HCW-1:0]    effh;

  // Position counters.
  logic [XW-1:0]  nx_q, ocol_q;
  logic [NYW-1:0] ny_q;
  logic [RW-1:0]  orow_q;

  // Input stage signals.
  logic s_ready, s_acc, done, adv, primed, emit, s_last, step;
  logic col_end, ocol_end, orow_end;

  // Stage 1: accepted beat, line memory read data.
  logic           v1_q, emit1_q, last1_q;
  pix_t           byte1_q;
  logic [XW-1:0]  x1_q, c1_q;
  logic [RW-1:0]  r1_q;
  pix_t           lb_rd_q [LINE_BUFS];
  pix_t           lb_wd   [LINE_BUFS];
  pix_t           g_rd_q;
  pix_t           newcol  [WIN_ROWS];
  logic [WIN_ROWS-1:0] rowok_d;
  logic [WIN_COLS-1:0] colok_d;
  pix_t           gsh_q [3];

  // Stage 2: pixel window.
  logic           pv2_q, last2_q, site_g2_q, odd2_q;
  logic [XW-1:0]  c2_q;
  logic [WIN_ROWS-1:0] rowok_q;
  logic [WIN_COLS-1:0] colok_q;
  pix_t           win_q [WIN_ROWS][WIN_COLS];
  pix_t           m     [WIN_ROWS][WIN_COLS];
  pix_t           gc, gdl, gdr, gul, gur;

  // Stage 3: greens and neighbors for the final pixel.
  logic pv3_q, last3_q, site_g3_q, odd3_q;
  pix_t gc3_q, gdl3_q, gdr3_q, gul3_q, gur3_q, cen3_q;
  pix_t otl3_q, otr3_q, obl3_q, obr3_q, up3_q, dn3_q, lf3_q, rt3_q;
  pix_t diag, vert, horz;
  pixel_t pix_d;

  // Output register and skid register.
  pixel_t out_q, skid_q;
  logic   out_v_q, skid_full_q, en, push, pop;

  // Green of the previous output row at red and blue sites.
  pix_t g_mem [MAX_WIDTH];

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q <= RESET_WIDTH;
      cfg_h_q <= RESET_HEIGHT;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_FRAME_WIDTH:  cfg_w_q <= cfg_wdata_i;
        REG_FRAME_HEIGHT: cfg_h_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Clamp the frame size to the supported range.
  always_comb begin
    if (EWW'(cfg_w_q) < EWW'(MIN_SIZE)) begin
      effw = WCW'(MIN_SIZE);
    end else if (EWW'(cfg_w_q) > EWW'(MAX_WIDTH)) begin
      effw = WCW'(MAX_WIDTH);
    end else begin
      effw = WCW'(cfg_w_q);
    end
    if (EHW'(cfg_h_q) < EHW'(MIN_SIZE)) begin
      effh = HCW'(MIN_SIZE);
    end else if (EHW'(cfg_h_q) > EHW'(MAX_HEIGHT)) begin
      effh = HCW'(MAX_HEIGHT);
    end else begin
      effh = HCW'(cfg_h_q);
    end
  end

  // The whole pipeline moves unless the skid register holds a beat.
  assign en      = !skid_full_q;
  assign s_ready = en;
  assign s_acc   = s_axis_tvalid_i && s_ready;

  // Decide whether a beat advances the stream and whether it emits a pixel.
  always_comb begin
    done     = NYW'(effh) <= ny_q;
    adv      = done || (s_axis_tuser_i != KIND_FLUSH);
    primed   = (ny_q > NYW'(LAG)) || ((ny_q == NYW'(LAG)) && (nx_q >= XW'(LAG)));
    emit     = adv && primed;
    col_end  = (WCW'(nx_q) + WCW'(1)) == effw;
    ocol_end = (WCW'(ocol_q) + WCW'(1)) == effw;
    orow_end = (HCW'(orow_q) + HCW'(1)) == effh;
    s_last   = emit && orow_end && ocol_end;
    step     = s_acc && adv;
  end

  // Input and output positions; all return to zero after the last pixel.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nx_q   <= '0;
      ny_q   <= '0;
      ocol_q <= '0;
      orow_q <= '0;
    end else if (step) begin
      if (s_last) begin
        nx_q   <= '0;
        ny_q   <= '0;
        ocol_q <= '0;
        orow_q <= '0;
      end else begin
        if (col_end) begin
          nx_q <= '0;
          ny_q <= ny_q + NYW'(1);
        end else begin
          nx_q <= nx_q + XW'(1);
        end
        if (emit) begin
          if (ocol_end) begin
            ocol_q <= '0;
            orow_q <= orow_q + RW'(1);
          end else begin
            ocol_q <= ocol_q + XW'(1);
          end
        end
      end
    end
  end

  // Stage 1 control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      emit1_q <= 1'b0;
      last1_q <= 1'b0;
    end else if (en) begin
      v1_q    <= step;
      emit1_q <= step && emit;
      last1_q <= s_last;
    end
  end

  // Stage 1 payload.
  always_ff @(posedge clk_i) begin
    if (en) begin
      byte1_q <= s_axis_tdata_i[RAW_W-1 -: PIX_W];
      x1_q    <= nx_q;
      c1_q    <= ocol_q;
      r1_q    <= orow_q;
    end
  end

  // Line memory chain: each memory passes its old row down to the next.
  always_comb begin
    lb_wd[0] = byte1_q;
    for (int i = 1; i < LINE_BUFS; i++) begin
      lb_wd[i] = lb_rd_q[i-1];
    end
  end

  for (genvar gi = 0; gi < LINE_BUFS; gi++) begin : g_line
    pix_t lb_mem [MAX_WIDTH];

    always_ff @(posedge clk_i) begin
      if (en && v1_q) begin
        lb_mem[x1_q] <= lb_wd[gi];
      end
      if (en) begin
        lb_rd_q[gi] <= lb_mem[nx_q];
      end
    end
  end

  // Green store: read one column ahead, wrapping to column zero at the end of
  // a row, and write the current red or blue site.
  always_ff @(posedge clk_i) begin
    if (en && pv2_q && !site_g2_q) begin
      g_mem[c2_q] <= gc;
    end
    if (en) begin
      g_rd_q <= g_mem[ocol_end ? '0 : ocol_q + XW'(1)];
    end
  end

  // New window column, newest row at the bottom.
  always_comb begin
    newcol[WIN_ROWS-1] = byte1_q;
    for (int j = 0; j < LINE_BUFS; j++) begin
      newcol[j] = lb_rd_q[LINE_BUFS-1-j];
    end
  end

  // Frame-bound masks for the rows and columns of the window.
  always_comb begin
    for (int j = 0; j < WIN_ROWS; j++) begin
      if (j < ROW_TOP) begin
        rowok_d[j] = r1_q >= RW'(ROW_TOP - j);
      end else begin
        rowok_d[j] = ((HCW+1)'(r1_q) + (HCW+1)'(j - ROW_TOP)) < (HCW+1)'(effh);
      end
    end
    for (int k = 0; k < WIN_COLS; k++) begin
      if (k < LAG) begin
        colok_d[k] = c1_q >= XW'(LAG - k);
      end else begin
        colok_d[k] = ((WCW+1)'(c1_q) + (WCW+1)'(k - LAG)) < (WCW+1)'(effw);
      end
    end
  end

  // Stage 2 control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv2_q   <= 1'b0;
      last2_q <= 1'b0;
    end else if (en) begin
      pv2_q   <= emit1_q;
      last2_q <= last1_q;
    end
  end

  // Stage 2 payload: window shift, masks and green history.
  always_ff @(posedge clk_i) begin
    if (en) begin
      c2_q      <= c1_q;
      site_g2_q <= r1_q[0] ^ c1_q[0];
      odd2_q    <= r1_q[0];
      rowok_q   <= rowok_d;
      colok_q   <= colok_d;
    end
    if (en && v1_q) begin
      for (int j = 0; j < WIN_ROWS; j++) begin
        for (int k = 0; k < WIN_COLS - 1; k++) begin
          win_q[j][k] <= win_q[j][k+1];
        end
        win_q[j][WIN_COLS-1] <= newcol[j];
      end
    end
    if (en && emit1_q) begin
      gsh_q[0] <= g_rd_q;
      gsh_q[1] <= gsh_q[0];
      gsh_q[2] <= gsh_q[1];
    end
  end

  // Masked window and the three interpolated greens.
  always_comb begin
    for (int j = 0; j < WIN_ROWS; j++) begin
      for (int k = 0; k < WIN_COLS; k++) begin
        m[j][k] = (rowok_q[j] && colok_q[k]) ? win_q[j][k] : '0;
      end
    end
    gc  = green_at(m[2][3], m[2][2], m[2][4], m[1][3], m[3][3],
                   m[2][1], m[2][5], m[0][3], m[4][3]);
    gdl = green_at(m[3][2], m[3][1], m[3][3], m[2][2], m[4][2],
                   m[3][0], m[3][4], m[1][2], m[5][2]);
    gdr = green_at(m[3][4], m[3][3], m[3][5], m[2][4], m[4][4],
                   m[3][2], m[3][6], m[1][4], m[5][4]);
    if (!(rowok_q[3] && colok_q[2])) gdl = '0;
    if (!(rowok_q[3] && colok_q[4])) gdr = '0;
    gul = (rowok_q[1] && colok_q[2]) ? gsh_q[2] : '0;
    gur = (rowok_q[1] && colok_q[4]) ? gsh_q[0] : '0;
  end

  // Stage 3 control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv3_q   <= 1'b0;
      last3_q <= 1'b0;
    end else if (en) begin
      pv3_q   <= pv2_q;
      last3_q <= last2_q;
    end
  end

  // Stage 3 payload.
  always_ff @(posedge clk_i) begin
    if (en) begin
      site_g3_q <= site_g2_q;
      odd3_q    <= odd2_q;
      gc3_q     <= gc;
      gdl3_q    <= gdl;
      gdr3_q    <= gdr;
      gul3_q    <= gul;
      gur3_q    <= gur;
      cen3_q    <= m[2][3];
      otl3_q    <= m[1][2];
      otr3_q    <= m[1][4];
      obl3_q    <= m[3][2];
      obr3_q    <= m[3][4];
      up3_q     <= m[1][3];
      dn3_q     <= m[3][3];
      lf3_q     <= m[2][2];
      rt3_q     <= m[2][4];
    end
  end

  // Final pixel: diagonal fill at red and blue sites, averages at green sites.
  always_comb begin
    diag = dir_pick(otl3_q, obr3_q, lap(gc3_q, gul3_q, gdr3_q),
                    otr3_q, obl3_q, lap(gc3_q, gur3_q, gdl3_q));
    vert = half_sum(up3_q, dn3_q);
    horz = half_sum(lf3_q, rt3_q);
    pix_d.last = last3_q;
    if (site_g3_q) begin
      pix_d.red   = odd3_q ? vert : horz;
      pix_d.green = cen3_q;
      pix_d.blue  = odd3_q ? horz : vert;
    end else if (!odd3_q) begin
      pix_d.red   = cen3_q;
      pix_d.green = gc3_q;
      pix_d.blue  = diag;
    end else begin
      pix_d.red   = diag;
      pix_d.green = gc3_q;
      pix_d.blue  = cen3_q;
    end
  end

  assign push = en && pv3_q;
  assign pop  = out_v_q && m_axis_tready_i;

  // Output register with one skid register behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q     <= 1'b0;
      skid_full_q <= 1'b0;
    end else if (skid_full_q) begin
      if (pop) begin
        skid_full_q <= 1'b0;
      end
    end else if (push) begin
      if (!out_v_q || pop) begin
        out_v_q <= 1'b1;
      end else begin
        skid_full_q <= 1'b1;
      end
    end else if (pop) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_full_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (push) begin
      if (!out_v_q || pop) begin
        out_q <= pix_d;
      end else begin
        skid_q <= pix_d;
      end
    end
  end

  assign s_axis_tready_o = s_ready;
  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = {out_q.blue, out_q.green, out_q.red};
  assign m_axis_tlast_o  = out_q.last;

`ifndef SYNTH
  // The skid register only holds a beat while the output register is full.
  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_full_q |-> out_v_q)
    else $error("skid register full while output register empty");

  // The skid register fills only after a stalled output beat.
  a_skid_fill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_full_q) |-> $past(out_v_q && !m_axis_tready_i))
    else $error("skid register filled without a stalled output");

  // Emitting the last pixel of a frame returns every position to zero.
  a_frame_wrap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && s_last) |=> (nx_q == '0 && ny_q == '0 && ocol_q == '0 && orow_q == '0))
    else $error("positions not cleared after the last pixel of a frame");
`endif

endmodule
